[sv/mf3_pkg.sv]
// Shared types, constants and compare functions for the 3x3 median filter.
// Used by mf3_window, mf3_median and median_filter_3x3; depends on nothing.
package mf3_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT    = 2048;
  localparam int unsigned MAX_CHANNELS_DEFAULT = 4;
  localparam int unsigned SAMPLE_W             = 8;
  localparam int unsigned TAP_COUNT            = 9;

  // Row limit is fixed by the 11-bit row coordinate
  localparam logic [11:0] ROW_LIMIT            = 12'd2048;
  localparam logic [11:0] MIN_SIDE             = 12'd3;

  localparam logic [11:0] WIDTH_RESET          = 12'd640;
  localparam logic [11:0] HEIGHT_RESET         = 12'd480;
  localparam logic [2:0]  CHANNELS_RESET       = 3'd3;
  localparam logic [2:0]  MARGIN_RESET         = 3'd3;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_BORDER_MARGIN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [2:0]  channel_count;
    logic [2:0]  border_margin;
  } cfg_t;

  // Per-result side information carried along the median pipeline
  typedef struct packed {
    logic [10:0] center_x;
    logic [10:0] center_y;
    logic        border;
    logic [2:0]  nch;
  } meta_t;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] md;
    logic [7:0] lo;
  } trio_t;

  function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic trio_t sort3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
    logic [7:0] x1;
    logic [7:0] y1;
    logic [7:0] t;
    trio_t      r;
    x1   = min8(a, b);
    y1   = max8(a, b);
    r.lo = min8(x1, c);
    t    = max8(x1, c);
    r.md = min8(y1, t);
    r.hi = max8(y1, t);
    return r;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return max8(min8(a, b), min8(max8(a, b), c));
  endfunction

endpackage

[sv/mf3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mf3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mf3_window.sv]
// Position counters, two line-store RAMs with read-modify-write forwarding,
// and the 3x3 window registers. Depends on mf3_pkg and mf3_ram.
module mf3_window #(
  parameter int unsigned MAX_WIDTH    = mf3_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_CHANNELS = mf3_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mf3_pkg::cfg_t                         cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  frame_start_i,
  input  logic [8*MAX_CHANNELS-1:0]             pixel_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [8:0][8*MAX_CHANNELS-1:0]        taps_o,
  output mf3_pkg::meta_t                        meta_o
);

  localparam int unsigned LW = 8 * MAX_CHANNELS;
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (AW + 1 > 12) ? AW + 1 : 12;

  // Clamped configuration
  logic [WW-1:0] iw_ext;
  logic [WW-1:0] w_lim;
  logic [11:0]   h_lim;
  logic [2:0]    m_lim;
  logic [2:0]    nch_lim;

  assign iw_ext  = WW'(cfg_i.image_width);
  assign w_lim   = (iw_ext < WW'(mf3_pkg::MIN_SIDE)) ? WW'(mf3_pkg::MIN_SIDE) :
                   (iw_ext > WW'(MAX_WIDTH))         ? WW'(MAX_WIDTH) : iw_ext;
  assign h_lim   = (cfg_i.image_height < mf3_pkg::MIN_SIDE) ? mf3_pkg::MIN_SIDE :
                   (cfg_i.image_height > mf3_pkg::ROW_LIMIT) ? mf3_pkg::ROW_LIMIT :
                   cfg_i.image_height;
  assign m_lim   = (cfg_i.border_margin == 3'd0) ? 3'd1 : cfg_i.border_margin;
  assign nch_lim = (cfg_i.channel_count == 3'd0) ? 3'd1 :
                   (cfg_i.channel_count > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) :
                   cfg_i.channel_count;

  // Position counters
  logic [AW-1:0] col_q, col_d, col_cur;
  logic [10:0]   row_q, row_d, row_cur;
  logic [11:0]   row_inc;
  logic          col_wrap;
  logic          acc;

  // Stage 1: item whose line-store read is in flight
  logic          v1_q;
  logic [AW-1:0] col1_q;
  logic [10:0]   row1_q;
  logic [LW-1:0] pix1_q;
  logic          fwd_q;
  logic [LW-1:0] fwd_up_q;
  logic [LW-1:0] fwd_mid_q;
  logic [LW-1:0] up_rd, mid_rd, up1, mid1;
  logic          produce1, adv1, ready2;

  // Stage 2: window taps for the median pipeline
  logic                  v2_q;
  logic [8:0][LW-1:0]    taps_q;
  mf3_pkg::meta_t        meta_q;
  logic [5:0][LW-1:0]    win_q;

  logic [AW-1:0] cx;
  logic [10:0]   cy;
  logic [31:0]   cx_ext;
  logic          border;

  assign acc      = in_valid_i && in_ready_o;
  assign col_cur  = frame_start_i ? '0 : col_q;
  assign row_cur  = frame_start_i ? '0 : row_q;
  assign col_wrap = (WW'(col_cur) + WW'(1)) >= w_lim;
  assign row_inc  = 12'(row_cur) + 12'd1;

  always_comb begin
    if (col_wrap) begin
      col_d = '0;
      row_d = (row_inc >= h_lim) ? 11'd0 : row_inc[10:0];
    end else begin
      col_d = AW'(col_cur + 1'b1);
      row_d = (12'(row_cur) >= h_lim) ? 11'd0 : row_cur;
    end
  end

  assign produce1   = (row1_q != 11'd0) && (col1_q != '0);
  assign ready2     = !v2_q || out_ready_i;
  assign adv1       = v1_q && (!produce1 || ready2);
  assign in_ready_o = !v1_q || adv1;

  // A read issued while the previous item writes the same entry sees stale data
  assign up1  = fwd_q ? fwd_up_q  : up_rd;
  assign mid1 = fwd_q ? fwd_mid_q : mid_rd;

  mf3_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (col1_q),
    .wdata_i (mid1),
    .re_i    (acc),
    .raddr_i (col_cur),
    .rdata_o (up_rd)
  );

  mf3_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (col1_q),
    .wdata_i (pix1_q),
    .re_i    (acc),
    .raddr_i (col_cur),
    .rdata_o (mid_rd)
  );

  assign cx     = col1_q - 1'b1;
  assign cy     = row1_q - 11'd1;
  assign cx_ext = 32'(cx);
  assign border = (WW'(cx) < WW'(m_lim)) || (cy < 11'(m_lim)) ||
                  ((WW+1)'(cx) + (WW+1)'(m_lim) >= (WW+1)'(w_lim)) ||
                  ((12'(cy) + 12'(m_lim)) >= h_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      fwd_q <= 1'b0;
      v2_q  <= 1'b0;
      win_q <= '0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= adv1 && (col1_q == col_cur);
      end
      if (acc) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        win_q[2:0] <= win_q[5:3];
        win_q[3]   <= up1;
        win_q[4]   <= mid1;
        win_q[5]   <= pix1_q;
      end
      if (adv1 && produce1) begin
        v2_q <= 1'b1;
      end else if (out_ready_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      col1_q    <= col_cur;
      row1_q    <= row_cur;
      pix1_q    <= pixel_i;
      fwd_up_q  <= mid1;
      fwd_mid_q <= pix1_q;
    end
    if (adv1 && produce1) begin
      taps_q[5:0]     <= win_q;
      taps_q[6]       <= up1;
      taps_q[7]       <= mid1;
      taps_q[8]       <= pix1_q;
      meta_q.center_x <= cx_ext[10:0];
      meta_q.center_y <= cy;
      meta_q.border   <= border;
      meta_q.nch      <= nch_lim;
    end
  end

  assign out_valid_o = v2_q;
  assign taps_o      = taps_q;
  assign meta_o      = meta_q;

endmodule

[sv/mf3_median.sv]
// Three-stage median-of-nine per channel: sort row triples, combine, final
// median with border and channel zeroing. Depends on mf3_pkg.
module mf3_median #(
  parameter int unsigned MAX_CHANNELS = mf3_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [8:0][8*MAX_CHANNELS-1:0] taps_i,
  input  mf3_pkg::meta_t                 meta_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mf3_pkg::meta_t                 meta_o,
  output logic [3:0][7:0]                med_o
);

  logic va_q, vb_q, vc_q;
  logic ready_a, ready_b, ready_c;

  mf3_pkg::trio_t [MAX_CHANNELS-1:0][2:0] tri_d, tri_q;
  mf3_pkg::trio_t [MAX_CHANNELS-1:0]      cmb_d, cmb_q;
  logic [3:0][7:0]                        med_d, med_q;
  mf3_pkg::meta_t                         meta_a_q, meta_b_q, meta_c_q;

  assign ready_c    = !vc_q || out_ready_i;
  assign ready_b    = !vb_q || ready_c;
  assign ready_a    = !va_q || ready_b;
  assign in_ready_o = ready_a;

  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      for (int r = 0; r < 3; r++) begin
        tri_d[k][r] = mf3_pkg::sort3(taps_i[3*r][8*k +: 8], taps_i[3*r+1][8*k +: 8],
                                     taps_i[3*r+2][8*k +: 8]);
      end
    end
  end

  // Median of nine = median of (max of row minima, median of row medians,
  // min of row maxima)
  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      cmb_d[k].lo = mf3_pkg::max8(mf3_pkg::max8(tri_q[k][0].lo, tri_q[k][1].lo),
                                  tri_q[k][2].lo);
      cmb_d[k].md = mf3_pkg::med3(tri_q[k][0].md, tri_q[k][1].md, tri_q[k][2].md);
      cmb_d[k].hi = mf3_pkg::min8(mf3_pkg::min8(tri_q[k][0].hi, tri_q[k][1].hi),
                                  tri_q[k][2].hi);
    end
  end

  always_comb begin
    med_d = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (!meta_b_q.border && (3'(k) < meta_b_q.nch)) begin
        med_d[k] = mf3_pkg::med3(cmb_q[k].lo, cmb_q[k].md, cmb_q[k].hi);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= in_valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
      if (ready_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      tri_q    <= tri_d;
      meta_a_q <= meta_i;
    end
    if (ready_b && va_q) begin
      cmb_q    <= cmb_d;
      meta_b_q <= meta_a_q;
    end
    if (ready_c && vb_q) begin
      med_q    <= med_d;
      meta_c_q <= meta_b_q;
    end
  end

  assign out_valid_o = vc_q;
  assign meta_o      = meta_c_q;
  assign med_o       = med_q;

endmodule

[sv/median_filter_3x3.sv]
// 3x3 median filter top level: configuration registers, window, median pipe.
// Depends on mf3_pkg, mf3_ram, mf3_window and mf3_median.
//
// Usage:
//   Pixels enter on the s_axis channel in raster order, one per transfer;
//   tuser marks the first pixel of a frame and clears the position counters.
//   For each pixel at row >= 1 and column >= 1 one result leaves on m_axis
//   for center (row-1, col-1); other pixels produce nothing. Each channel is
//   the median of its nine neighbors, or zero inside the border margin or
//   for channels at or above channel_count.
//   Throughput is one pixel per cycle while m_axis_tready stays high: each
//   line-store RAM does one read and one write per cycle, and the window and
//   median stages are fully pipelined. A receiver stall backs up through the
//   skid-free stage valids; the input keeps accepting until every pipeline
//   register is occupied, so four results and one pixel are held before
//   s_axis_tready drops. Reset clears the counters, the window and the
//   pipeline; line-store contents stay undefined until the first row has
//   been written. Write registers only while the pipeline is empty.
module median_filter_3x3 #(
  parameter int unsigned MAX_WIDTH    = mf3_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_CHANNELS = mf3_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_0, sample_1, sample_2, sample_3
  input  logic        s_axis_tuser,   // frame_start
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // center_x, center_y, median_0..median_3, pad
);

  localparam int unsigned LW = 8 * MAX_CHANNELS;

  mf3_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= mf3_pkg::WIDTH_RESET;
      cfg_q.image_height  <= mf3_pkg::HEIGHT_RESET;
      cfg_q.channel_count <= mf3_pkg::CHANNELS_RESET;
      cfg_q.border_margin <= mf3_pkg::MARGIN_RESET;
    end else if (cfg_we_i) begin
      unique case (mf3_pkg::cfg_reg_e'(cfg_index_i))
        mf3_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i;
        mf3_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i;
        mf3_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[2:0];
        mf3_pkg::REG_BORDER_MARGIN: cfg_q.border_margin <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic                 win_valid, win_ready;
  logic [8:0][LW-1:0]   win_taps;
  mf3_pkg::meta_t       win_meta;
  mf3_pkg::meta_t       out_meta;
  logic [3:0][7:0]      out_med;

  mf3_window #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .frame_start_i (s_axis_tuser),
    .pixel_i       (s_axis_tdata[LW-1:0]),
    .out_valid_o   (win_valid),
    .out_ready_i   (win_ready),
    .taps_o        (win_taps),
    .meta_o        (win_meta)
  );

  mf3_median #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_valid),
    .in_ready_o  (win_ready),
    .taps_i      (win_taps),
    .meta_i      (win_meta),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .meta_o      (out_meta),
    .med_o       (out_med)
  );

  assign m_axis_tdata = {2'b00, out_med[3], out_med[2], out_med[1], out_med[0],
                         out_meta.center_y, out_meta.center_x};

  // Window output held while the median pipe is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid && !win_ready) |=> (win_valid && $stable(win_meta)))
    else $error("window result changed while stalled");

  // A margin of at least one keeps the first row and column in the border
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid && !win_meta.border) |->
      (win_meta.center_x != 11'd0 && win_meta.center_y != 11'd0))
    else $error("edge center not flagged as border");

  // Input backpressure only comes from a stalled window output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (win_valid && !win_ready))
    else $error("input stalled without downstream backpressure");

endmodule
